/* rtl/sis_pkg.sv */
// shared widths, command and error codes and state type of the sparse index set
package sis_pkg;

   localparam int MAX_ENTRIES_DEF = 1024;
   localparam int CAP_DEFAULT     = 1024;

   localparam int FIELD_W = 11;
   localparam int CMD_W   = 4;
   localparam int RPOS_W  = 10;
   localparam int ERR_W   = 3;

   localparam int FIELD_MAX = (2 ** FIELD_W) - 1;

   localparam logic [CMD_W-1:0] CMD_FILL   = 4'd0;
   localparam logic [CMD_W-1:0] CMD_RESIZE = 4'd1;
   localparam logic [CMD_W-1:0] CMD_SET    = 4'd2;
   localparam logic [CMD_W-1:0] CMD_ADD    = 4'd3;
   localparam logic [CMD_W-1:0] CMD_ERASE  = 4'd4;
   localparam logic [CMD_W-1:0] CMD_GET    = 4'd5;
   localparam logic [CMD_W-1:0] CMD_POS    = 4'd6;
   localparam logic [CMD_W-1:0] CMD_EXISTS = 4'd7;
   localparam logic [CMD_W-1:0] CMD_DRAW   = 4'd8;
   localparam logic [CMD_W-1:0] CMD_LAST   = 4'd9;

   localparam logic [ERR_W-1:0] ERR_OK     = 3'd0;
   localparam logic [ERR_W-1:0] ERR_ID     = 3'd1;
   localparam logic [ERR_W-1:0] ERR_DUP    = 3'd2;
   localparam logic [ERR_W-1:0] ERR_ABSENT = 3'd3;
   localparam logic [ERR_W-1:0] ERR_POS    = 3'd4;
   localparam logic [ERR_W-1:0] ERR_EMPTY  = 3'd5;
   localparam logic [ERR_W-1:0] ERR_LEN    = 3'd6;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_FILL,
      S_LOOK,
      S_CHECK,
      S_FIX
   } state_type;

endpackage

/* rtl/sis_req_if.sv */
// command channel of the sparse index set
interface sis_req_if;
   import sis_pkg::*;

   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [FIELD_W-1:0]  operand;
   logic [RPOS_W-1:0]   random_position;

   modport source (output valid, cmd, operand, random_position, input ready);
   modport sink   (input valid, cmd, operand, random_position, output ready);
endinterface

/* rtl/sis_rsp_if.sv */
// result channel of the sparse index set
interface sis_rsp_if;
   import sis_pkg::*;

   logic                valid;
   logic                ready;
   logic [FIELD_W-1:0]  result_value;
   logic                is_member;
   logic [ERR_W-1:0]    error_code;
   logic [FIELD_W-1:0]  member_count;

   modport source (output valid, result_value, is_member, error_code, member_count,
                   input ready);
   modport sink   (input valid, result_value, is_member, error_code, member_count,
                   output ready);
endinterface

/* rtl/sis_csr_if.sv */
// capacity register write channel of the sparse index set
interface sis_csr_if;
   import sis_pkg::*;

   logic                valid;
   logic                ready;
   logic [FIELD_W-1:0]  capacity_in_use;

   modport source (output valid, capacity_in_use, input ready);
   modport sink   (input valid, capacity_in_use, output ready);
endinterface

/* rtl/sis_ram.sv */
// simple dual-port synchronous ram, one write and one registered read port
module sis_ram #(
   parameter int DEPTH = sis_pkg::MAX_ENTRIES_DEF,
   parameter int WIDTH = sis_pkg::FIELD_W
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/sis_cap_reg.sv */
// capacity register with saturation into the legal range
module sis_cap_reg #(
   parameter int MAX_ENTRIES = sis_pkg::MAX_ENTRIES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   sis_csr_if.sink                      csr_chan,
   output logic [sis_pkg::FIELD_W-1:0]  cap
);
   import sis_pkg::*;

   localparam int CAP_MAX   = (MAX_ENTRIES < FIELD_MAX) ? MAX_ENTRIES : FIELD_MAX;
   localparam int CAP_RESET = (MAX_ENTRIES < CAP_DEFAULT) ? MAX_ENTRIES : CAP_DEFAULT;

   logic [FIELD_W-1:0] cap_ff;
   logic [FIELD_W-1:0] cap_in;

   assign csr_chan.ready = 1'b1;

   // clamp the written word into [1, CAP_MAX]
   always_comb begin
      cap_in = cap_ff;
      if (csr_chan.valid) begin
         priority if (csr_chan.capacity_in_use == '0) begin
            cap_in = FIELD_W'(1);
         end else if (csr_chan.capacity_in_use > FIELD_W'(CAP_MAX)) begin
            cap_in = FIELD_W'(CAP_MAX);
         end else begin
            cap_in = csr_chan.capacity_in_use;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= FIELD_W'(CAP_RESET);
      end else begin
         cap_ff <= cap_in;
      end
   end

   assign cap = cap_ff;

endmodule

/* rtl/sparse_index_set.sv */
// sparse index set: dense member list plus position map held in two rams
// sequence: resize, set, get, position, draw, get last: a look state, then the result
//   exists, add, erase: look and check states; erase that moves the last member: plus a fix state
// one command in flight; a fill first walks the rams up to the capacity (ram write walk)
// reset: synchronous; a clearing pass then writes the identity into every ram entry,
//   one entry a cycle, before the first command is taken
module sparse_index_set #(
   parameter int MAX_ENTRIES = sis_pkg::MAX_ENTRIES_DEF
) (
   input  logic     clock,
   input  logic     reset,
   sis_req_if.sink  req_chan,
   sis_rsp_if.source rsp_chan,
   sis_csr_if.sink  csr_chan
);
   import sis_pkg::*;

   // ids and positions never reach past the largest capacity, which the field width bounds
   localparam int CAP_MAX   = (MAX_ENTRIES < FIELD_MAX) ? MAX_ENTRIES : FIELD_MAX;
   localparam int CAP_RESET = (MAX_ENTRIES < CAP_DEFAULT) ? MAX_ENTRIES : CAP_DEFAULT;
   localparam int DEPTH     = CAP_MAX;
   localparam int AW        = $clog2(DEPTH);

   localparam logic [FIELD_W-1:0] DEPTH_VAL = FIELD_W'(DEPTH);
   localparam logic [FIELD_W-1:0] ONE       = FIELD_W'(1);

   // configuration register
   logic [FIELD_W-1:0] cap;

   sis_cap_reg #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_cap (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cap      (cap)
   );

   // dense member list: slot -> id
   logic          d_we, d_re;
   logic [AW-1:0] d_waddr, d_raddr;
   logic [AW-1:0] d_wdata, d_rdata;

   sis_ram #(
      .DEPTH (DEPTH),
      .WIDTH (AW)
   ) u_dense (
      .clock (clock),
      .we    (d_we),
      .waddr (d_waddr),
      .wdata (d_wdata),
      .re    (d_re),
      .raddr (d_raddr),
      .rdata (d_rdata)
   );

   // position map: id -> slot (or the capacity once erased)
   logic               m_we, m_re;
   logic [AW-1:0]      m_waddr, m_raddr;
   logic [FIELD_W-1:0] m_wdata, m_rdata;

   sis_ram #(
      .DEPTH (DEPTH),
      .WIDTH (FIELD_W)
   ) u_map (
      .clock (clock),
      .we    (m_we),
      .waddr (m_waddr),
      .wdata (m_wdata),
      .re    (m_re),
      .raddr (m_raddr),
      .rdata (m_rdata)
   );

   // sequencer state
   state_type          state_ff, state_in;
   logic [FIELD_W-1:0] len_ff, len_in;
   logic [FIELD_W-1:0] sweep_ff, sweep_in;
   logic [FIELD_W-1:0] k_ff, k_in;
   logic [AW-1:0]      last_ff, last_in;

   // command word held for the whole sequence
   logic [CMD_W-1:0]   cmd_ff;
   logic [FIELD_W-1:0] opnd_ff;
   logic [RPOS_W-1:0]  rpos_ff;

   // output register
   logic               rsp_valid_ff;
   logic [FIELD_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_member_ff, rsp_member_in;
   logic [ERR_W-1:0]   rsp_err_ff, rsp_err_in;
   logic [FIELD_W-1:0] rsp_count_ff;

   logic               accept;
   logic               out_free;
   logic               finish;
   logic [FIELD_W-1:0] sweep_limit;
   logic               sweep_last;
   logic               id_ok;
   logic               member_hit;
   logic               erase_move;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;

   // the result slot is free, or is being emptied at this edge
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // clearing pass covers the whole ram, a fill only up to the capacity
   assign sweep_limit = (state_ff == S_CLEAR) ? DEPTH_VAL : cap;
   assign sweep_last  = (sweep_ff == sweep_limit - ONE);

   // full sparse-set test, valid in the check state: map entry in range and pointing back
   assign id_ok      = (opnd_ff < cap);
   assign member_hit = id_ok && (k_ff < len_ff) && (FIELD_W'(d_rdata) == opnd_ff);
   assign erase_move = (cmd_ff == CMD_ERASE) && member_hit && (k_ff != len_ff - ONE);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = (req_chan.cmd == CMD_FILL) ? S_FILL : S_LOOK;
            end
         end
         S_FILL: begin
            if (sweep_last) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            if (cmd_ff == CMD_ADD || cmd_ff == CMD_ERASE || cmd_ff == CMD_EXISTS) begin
               state_in = S_CHECK;
            end else if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_CHECK: begin
            if (out_free) begin
               state_in = erase_move ? S_FIX : S_IDLE;
            end
         end
         S_FIX: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ram accesses, state updates and the result word
   always_comb begin
      d_we          = 1'b0;
      d_waddr       = '0;
      d_wdata       = '0;
      d_re          = 1'b0;
      d_raddr       = '0;
      m_we          = 1'b0;
      m_waddr       = '0;
      m_wdata       = '0;
      m_re          = 1'b0;
      m_raddr       = '0;
      len_in        = len_ff;
      sweep_in      = sweep_ff;
      k_in          = k_ff;
      last_in       = last_ff;
      finish        = 1'b0;
      rsp_value_in  = '0;
      rsp_member_in = 1'b0;
      rsp_err_in    = ERR_OK;

      unique case (state_ff)
         S_CLEAR, S_FILL: begin
            // identity walk over both rams
            d_we     = 1'b1;
            d_waddr  = AW'(sweep_ff);
            d_wdata  = AW'(sweep_ff);
            m_we     = 1'b1;
            m_waddr  = AW'(sweep_ff);
            m_wdata  = sweep_ff;
            sweep_in = sweep_last ? '0 : sweep_ff + ONE;
         end
         S_IDLE: begin
            if (accept) begin
               // map entry of the operand, and the dense slot the command looks at
               m_re    = 1'b1;
               m_raddr = AW'(req_chan.operand);
               d_re    = 1'b1;
               unique case (req_chan.cmd)
                  CMD_GET:  d_raddr = AW'(req_chan.operand);
                  CMD_DRAW: d_raddr = AW'(req_chan.random_position);
                  default:  d_raddr = AW'(len_ff - ONE);
               endcase
               sweep_in = '0;
            end
         end
         S_LOOK: begin
            unique case (cmd_ff)
               CMD_ADD, CMD_ERASE, CMD_EXISTS: begin
                  // follow the map entry into the dense list; keep the last member
                  d_re    = 1'b1;
                  d_raddr = AW'(m_rdata);
                  k_in    = m_rdata;
                  last_in = d_rdata;
               end
               CMD_FILL: begin
                  finish = out_free;
                  if (out_free) begin
                     len_in = cap;
                  end
               end
               CMD_RESIZE: begin
                  finish = out_free;
                  if (opnd_ff > cap) begin
                     rsp_err_in = ERR_LEN;
                  end else if (out_free) begin
                     len_in = opnd_ff;
                  end
               end
               CMD_SET: begin
                  finish = out_free;
                  if (!id_ok) begin
                     rsp_err_in = ERR_ID;
                  end else if (out_free) begin
                     d_we    = 1'b1;
                     d_waddr = AW'(opnd_ff);
                     d_wdata = AW'(opnd_ff);
                     m_we    = 1'b1;
                     m_waddr = AW'(opnd_ff);
                     m_wdata = opnd_ff;
                  end
               end
               CMD_GET: begin
                  finish = out_free;
                  if (opnd_ff >= len_ff) begin
                     rsp_err_in = ERR_POS;
                  end else begin
                     rsp_value_in = FIELD_W'(d_rdata);
                  end
               end
               CMD_POS: begin
                  finish = out_free;
                  if (!id_ok) begin
                     rsp_err_in = ERR_ID;
                  end else begin
                     rsp_value_in = m_rdata;
                  end
               end
               CMD_DRAW: begin
                  finish = out_free;
                  priority if (len_ff == '0) begin
                     rsp_err_in = ERR_EMPTY;
                  end else if (FIELD_W'(rpos_ff) >= len_ff) begin
                     rsp_err_in = ERR_POS;
                  end else begin
                     rsp_value_in = FIELD_W'(d_rdata);
                  end
               end
               CMD_LAST: begin
                  finish = out_free;
                  if (len_ff == '0) begin
                     rsp_err_in = ERR_EMPTY;
                  end else begin
                     rsp_value_in = FIELD_W'(d_rdata);
                  end
               end
               default: begin
                  // unknown command: no effect
                  finish = out_free;
               end
            endcase
         end
         S_CHECK: begin
            if (out_free) begin
               unique case (cmd_ff)
                  CMD_EXISTS: begin
                     finish        = 1'b1;
                     rsp_member_in = member_hit;
                  end
                  CMD_ADD: begin
                     finish = 1'b1;
                     priority if (!id_ok) begin
                        rsp_err_in = ERR_ID;
                     end else if (member_hit) begin
                        rsp_err_in = ERR_DUP;
                     end else if (len_ff >= cap) begin
                        rsp_err_in = ERR_LEN;
                     end else begin
                        // append at the tail
                        d_we    = 1'b1;
                        d_waddr = AW'(len_ff);
                        d_wdata = AW'(opnd_ff);
                        m_we    = 1'b1;
                        m_waddr = AW'(opnd_ff);
                        m_wdata = len_ff;
                        len_in  = len_ff + ONE;
                     end
                  end
                  default: begin
                     // erase
                     priority if (!id_ok) begin
                        finish     = 1'b1;
                        rsp_err_in = ERR_ID;
                     end else if (!member_hit) begin
                        finish     = 1'b1;
                        rsp_err_in = ERR_ABSENT;
                     end else begin
                        // mark the id gone; the last member fills the hole
                        m_we    = 1'b1;
                        m_waddr = AW'(opnd_ff);
                        m_wdata = cap;
                        len_in  = len_ff - ONE;
                        if (erase_move) begin
                           d_we    = 1'b1;
                           d_waddr = AW'(k_ff);
                           d_wdata = last_ff;
                        end else begin
                           finish = 1'b1;
                        end
                     end
                  end
               endcase
            end
         end
         S_FIX: begin
            // second map write of an erase: moved member now sits at the freed slot
            if (out_free) begin
               finish  = 1'b1;
               m_we    = 1'b1;
               m_waddr = last_ff;
               m_wdata = k_ff;
            end
         end
         default: begin
            finish = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         len_ff   <= FIELD_W'(CAP_RESET);
         sweep_ff <= '0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         sweep_ff <= sweep_in;
      end
   end

   // operands and scratch words
   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      last_ff <= last_in;
      if (accept) begin
         cmd_ff  <= req_chan.cmd;
         opnd_ff <= req_chan.operand;
         rpos_ff <= req_chan.random_position;
      end
   end

   // result word register; a new word loads only when the old one has gone
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_member_ff <= rsp_member_in;
         rsp_err_ff    <= rsp_err_in;
         rsp_count_ff  <= len_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_value = rsp_value_ff;
   assign rsp_chan.is_member    = rsp_member_ff;
   assign rsp_chan.error_code   = rsp_err_ff;
   assign rsp_chan.member_count = rsp_count_ff;

`ifndef SYNTHESIS
   // the list never grows past the ram
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= DEPTH_VAL)
      else $error("member count beyond ram depth");

   // rams are only written by a running command or a walk
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !(d_we || m_we))
      else $error("ram write while idle");

   // an accepted word always starts a sequence
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != S_IDLE))
      else $error("accepted word dropped");

   // a result never appears from the idle or the clearing state
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) != S_IDLE && $past(state_ff) != S_CLEAR))
      else $error("result without a command");
`endif

endmodule
